FILE: src/kdb_pkg.sv
`default_nettype none
package kdb_pkg;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int DEB_W      = 8;
    localparam int HOLD_W     = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_TICKS   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_TICKS = 8'd1;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd20;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic long_press_event;
        logic short_press_event;
        logic released_event;
        logic pressed_event;
        logic stable_pressed;
    } result_t;

endpackage
`default_nettype wire

FILE: src/kdb_cfg.sv
`default_nettype none
module kdb_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kdb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output kdb_pkg::cfg_t                         cfg
);

    kdb_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= kdb_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= kdb_pkg::LONG_PRESS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                kdb_pkg::CFG_DEBOUNCE_TICKS: begin
                    cfg_reg.debounce_ticks <= cfg_data[kdb_pkg::DEB_W-1:0];
                end
                kdb_pkg::CFG_LONG_PRESS_TICKS: begin
                    cfg_reg.long_press_ticks <= cfg_data[kdb_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/kdb_core.sv
`default_nettype none
module kdb_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire logic           raw_pressed,
    input  wire kdb_pkg::cfg_t  cfg,
    output kdb_pkg::result_t    result
);

    logic                       level_reg, level_next;
    logic                       wait_reg, wait_next;
    logic [kdb_pkg::DEB_W-1:0]  wcnt_reg, wcnt_next;
    logic [kdb_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic                       lrep_reg, lrep_next;
    logic                       prev_reg, prev_next;

    always_comb begin
        level_next = level_reg;
        wait_next  = wait_reg;
        wcnt_next  = wcnt_reg;
        hold_next  = hold_reg;
        lrep_next  = lrep_reg;
        prev_next  = raw_pressed;
        result     = '0;

        if (level_reg && (hold_reg != '1)) begin
            hold_next = hold_reg + 1'b1;
        end

        if (wait_reg) begin
            if (wcnt_reg != '1) begin
                wcnt_next = wcnt_reg + 1'b1;
            end
        end else if (raw_pressed != prev_reg) begin
            wait_next = 1'b1;
            wcnt_next = '0;
        end

        if (wait_next && (wcnt_next >= cfg.debounce_ticks)) begin
            if (raw_pressed != level_reg) begin
                level_next = raw_pressed;
                if (raw_pressed) begin
                    result.pressed_event = 1'b1;
                    lrep_next = 1'b0;
                    hold_next = '0;
                end else begin
                    result.released_event = 1'b1;
                    if (!lrep_reg) begin
                        if (hold_next >= cfg.long_press_ticks) begin
                            result.long_press_event = 1'b1;
                        end else begin
                            result.short_press_event = 1'b1;
                        end
                    end
                end
            end
            wait_next = 1'b0;
        end

        if (level_next && !lrep_next && (hold_next >= cfg.long_press_ticks)) begin
            lrep_next = 1'b1;
            result.long_press_event = 1'b1;
        end

        result.stable_pressed = level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            wait_reg  <= 1'b0;
            wcnt_reg  <= '0;
            hold_reg  <= '0;
            lrep_reg  <= 1'b0;
            prev_reg  <= 1'b0;
        end else if (advance) begin
            level_reg <= level_next;
            wait_reg  <= wait_next;
            wcnt_reg  <= wcnt_next;
            hold_reg  <= hold_next;
            lrep_reg  <= lrep_next;
            prev_reg  <= prev_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/key_debounce_short_long_press_top.sv
// Key debounce with short-press and long-press detection.
// Input stream (s_): one item per millisecond tick, s_tdata[0] = raw_pressed.
// Result stream (m_): exactly one item per input item, in order, with
//   m_tdata[0] stable_pressed, [1] pressed_event, [2] released_event,
//   [3] short_press_event, [4] long_press_event; events are one-item pulses.
// Config channel: cfg_addr 0 = debounce_ticks (8 bit, reset 20),
//   cfg_addr 1 = long_press_ticks (16 bit, reset 1000); other addresses
//   are accepted and ignored. cfg_ready is always high. Write only while idle.
// Path: an item goes through the input register, then the result register
//   that drives m_tvalid. Throughput: one item per cycle unless stalled; the
//   tick state update is a single pass of counter increments and compares.
// Reset (aresetn low, synchronous): key released, no debounce wait, counters
//   cleared, configuration back to defaults, both stages empty.
// Stall: when m_tready is low the result register holds; one more item is
//   taken into the input register, after which s_tready drops until the
//   result is taken.
`default_nettype none
module key_debounce_short_long_press_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [0] raw_pressed
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] stable_pressed, [1] pressed_event, [2] released_event,
    // [3] short_press_event, [4] long_press_event
    output logic [7:0]                            m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kdb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    kdb_pkg::cfg_t    cfg;
    kdb_pkg::result_t result;
    kdb_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic             in_raw_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    kdb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kdb_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .raw_pressed (in_raw_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_raw_reg <= s_tdata[0];
        end
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule
`default_nettype wire

FILE: src/kdb_checker.sv
`default_nettype none
module kdb_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_press_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]) && (!m_tdata[2] || !m_tdata[0]))
        else $error("press or release event disagrees with stable state");

    a_short_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2] && !m_tdata[4])
        else $error("short press without release or with long press");

    a_long_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[0] || m_tdata[2])
        else $error("long press while released without release event");

endmodule

bind key_debounce_short_long_press_top kdb_checker u_kdb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
